### rtl/axmh_pkg.sv
// ----------------------------------------------------------------------------
// axmh_pkg
// Shared types, codes and reset constants for the axis move and homing
// sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package axmh_pkg;

  localparam int unsigned POS_WIDTH_DEF = 32;

  localparam logic [15:0] SLOW_START_RST    = 16'd1000;
  localparam logic [15:0] BASE_RATE_RST     = 16'd500;
  localparam logic [31:0] HOMING_TRAVEL_RST = 32'd200000;

  localparam int unsigned ADDR_W = 4;

  typedef enum logic [1:0] {
    REG_SLOW_START    = 2'd0,
    REG_BASE_RATE     = 2'd1,
    REG_HOMING_TRAVEL = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    CMD_MOTORS_ON  = 3'd0,
    CMD_MOTORS_OFF = 3'd1,
    CMD_MOVE       = 3'd2,
    CMD_GOTO       = 3'd3,
    CMD_CAL_TOGGLE = 3'd4,
    CMD_CAL_TICK   = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_MOTORS_ON,
    OP_MOTORS_OFF,
    OP_MOVE,
    OP_GOTO,
    OP_CAL_TOGGLE,
    OP_CAL_TICK
  } op_e;

  localparam logic [1:0] AXIS_STATUS = 2'd3;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [7:0]         arc_type;
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;
    logic signed [31:0] z_value;
    logic [15:0]        x_speed;
    logic [15:0]        y_speed;
    logic [1:0]         center_select;
    logic [3:0]         endstops;
    logic [31:0]        pos_x;
    logic [31:0]        pos_y;
    logic [31:0]        pos_z;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  axis;
    logic        active;
    logic        direction;
    logic [31:0] distance;
    logic [15:0] period;
    logic [15:0] start_period;
    logic [31:0] target;
    logic        load_position;
    logic [31:0] position_value;
    logic [7:0]  move_tag;
    logic [2:0]  status;
    logic        last;
  } out_item_t;

  typedef struct packed {
    op_e      op;
    in_item_t item;
  } entry_t;

  // front queue head toward the executor
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } head_t;

  typedef struct packed {
    logic [15:0] slow_start;
    logic [15:0] base_rate;
    logic [31:0] homing_travel;
  } cfg_t;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } back_st_e;

endpackage

`default_nettype wire

### rtl/axmh_front.sv
// ----------------------------------------------------------------------------
// axmh_front
// Accepts commands, decodes them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module axmh_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire axmh_pkg::in_item_t item_i,
  output logic                  full_o,
  output axmh_pkg::head_t       head_o,
  input  wire logic             pop_i
);
  import axmh_pkg::*;

  entry_t     ent_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  op_e        op;
  logic       do_push, do_pop;

  always_comb begin
    case (item_i.cmd)
      CMD_MOTORS_ON:  op = OP_MOTORS_ON;
      CMD_MOTORS_OFF: op = OP_MOTORS_OFF;
      CMD_MOVE:       op = OP_MOVE;
      CMD_GOTO:       op = OP_GOTO;
      CMD_CAL_TOGGLE: op = OP_CAL_TOGGLE;
      CMD_CAL_TICK:   op = OP_CAL_TICK;
      default:        op = OP_NOP;
    endcase
  end

  assign full_o  = (cnt_q == 2'd2);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && (cnt_q != 2'd0);
  assign head_o  = {(cnt_q != 2'd0), ent_q[rd_q]};

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wr_q].op   <= op;
      ent_q[wr_q].item <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

`default_nettype wire

### rtl/axmh_res_q.sv
// ----------------------------------------------------------------------------
// axmh_res_q
// Four-entry result queue in front of the output ports.
// ----------------------------------------------------------------------------
`default_nettype none

module axmh_res_q (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               wr_i,
  input  wire axmh_pkg::out_item_t data_i,
  output logic                    full_o,
  output logic                    empty_o,
  output axmh_pkg::out_item_t     data_o,
  input  wire logic               rd_i
);
  import axmh_pkg::*;

  out_item_t  mem_q [4];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q;
  logic       do_wr, do_rd;

  assign full_o  = (cnt_q == 3'd4);
  assign empty_o = (cnt_q == 3'd0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 2'd0;
      rd_q  <= 2'd0;
      cnt_q <= 3'd0;
    end else begin
      if (do_wr) wr_q <= wr_q + 2'd1;
      if (do_rd) rd_q <= rd_q + 2'd1;
      cnt_q <= cnt_q + {2'b0, do_wr} - {2'b0, do_rd};
    end
  end

endmodule

`default_nettype wire

### rtl/axmh_back.sv
// ----------------------------------------------------------------------------
// axmh_back
// Executes one decoded command: updates the axis records and flags, then
// emits one result beat per reported axis, or a single status beat.
// ----------------------------------------------------------------------------
`default_nettype none

module axmh_back #(
  parameter int unsigned POS_WIDTH = axmh_pkg::POS_WIDTH_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire axmh_pkg::cfg_t      cfg_i,
  input  wire axmh_pkg::head_t     head_i,
  output logic                    pop_o,
  output logic                    res_wr_o,
  output axmh_pkg::out_item_t     res_o,
  input  wire logic               res_full_i
);
  import axmh_pkg::*;

  localparam logic [31:0] PosMask =
    (POS_WIDTH >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << POS_WIDTH) - 64'd1);

  logic        act_q [3], act_d [3];
  logic        dir_q [3], dir_d [3];
  logic [31:0] dist_q [3], dist_d [3];
  logic [15:0] per_q [3], per_d [3];
  logic [15:0] sper_q [3], sper_d [3];
  logic [31:0] tgt_q [3], tgt_d [3];
  logic [7:0]  tag_q [3], tag_d [3];
  logic [31:0] ws_q [2], ws_d [2];
  logic        ld_q [2], ld_d [2];
  logic [31:0] ldv_q [2], ldv_d [2];
  logic        calib_q, calib_d, motors_q, motors_d, run_q, run_d;
  logic [1:0]  phase_q, phase_d;
  logic [1:0]  idx_q, idx_d, lastidx_q, lastidx_d;
  logic        stonly_q, stonly_d;
  back_st_e    st_q, st_d;
  logic        take, fin;

  in_item_t    it;
  logic [31:0] pos [3];
  logic [31:0] val [3];
  logic [15:0] sp [2];
  logic [31:0] t, half;

  assign it     = head_i.entry.item;
  assign pos[0] = it.pos_x & PosMask;
  assign pos[1] = it.pos_y & PosMask;
  assign pos[2] = it.pos_z & PosMask;
  assign val[0] = it.x_value;
  assign val[1] = it.y_value;
  assign val[2] = it.z_value;
  assign sp[0]  = it.x_speed;
  assign sp[1]  = it.y_speed;

  // sequencing
  always_comb begin
    st_d     = st_q;
    idx_d    = idx_q;
    res_wr_o = 1'b0;
    fin      = 1'b0;
    take     = 1'b0;
    case (st_q)
      ST_IDLE: begin
        take = head_i.valid;
      end
      ST_EMIT: begin
        if (!res_full_i) begin
          res_wr_o = 1'b1;
          if (idx_q == lastidx_q) begin
            fin  = 1'b1;
            take = head_i.valid;
          end else begin
            idx_d = idx_q + 2'd1;
          end
        end
      end
      default: st_d = ST_IDLE;
    endcase
    if (take) begin
      st_d  = ST_EMIT;
      idx_d = 2'd0;
    end else if (fin) begin
      st_d = ST_IDLE;
    end
  end

  assign pop_o = take;

  // record update
  always_comb begin
    t    = '0;
    half = '0;
    act_d = act_q; dir_d = dir_q; dist_d = dist_q; per_d = per_q;
    sper_d = sper_q; tgt_d = tgt_q; tag_d = tag_q; ws_d = ws_q;
    ld_d = ld_q; ldv_d = ldv_q;
    calib_d = calib_q; motors_d = motors_q; run_d = run_q; phase_d = phase_q;
    lastidx_d = lastidx_q;
    stonly_d  = stonly_q;
    if (take) begin
      ld_d  = '{default: 1'b0};
      ldv_d = '{default: '0};
      stonly_d  = 1'b1;
      lastidx_d = 2'd0;
      case (head_i.entry.op)
        OP_MOTORS_ON:  motors_d = 1'b1;
        OP_MOTORS_OFF: motors_d = 1'b0;
        OP_MOVE: begin
          stonly_d  = 1'b0;
          lastidx_d = 2'd2;
          for (int a = 0; a < 3; a++) begin
            if (val[a] == '0) begin
              act_d[a] = 1'b0;
              per_d[a] = '0;
            end else begin
              dir_d[a]  = ~val[a][31];
              dist_d[a] = val[a][31] ? (32'd0 - val[a]) : val[a];
              tgt_d[a]  = (pos[a] + val[a]) & PosMask;
              per_d[a]  = it.x_speed;
              sper_d[a] = (it.x_speed < cfg_i.slow_start) ? cfg_i.slow_start
                                                          : it.x_speed;
              act_d[a]  = 1'b1;
              tag_d[a]  = it.arc_type;
            end
          end
        end
        OP_GOTO: begin
          stonly_d  = 1'b0;
          lastidx_d = 2'd1;
          for (int a = 0; a < 2; a++) begin
            t = (it.center_select[a] ? (ws_q[a] >> 1) : val[a]) & PosMask;
            tgt_d[a]  = t;
            per_d[a]  = (sp[a] != '0) ? sp[a] : cfg_i.base_rate;
            sper_d[a] = cfg_i.slow_start;
            if (t > pos[a]) begin
              dir_d[a]  = 1'b1;
              dist_d[a] = t - pos[a];
            end else begin
              dir_d[a]  = 1'b0;
              dist_d[a] = pos[a] - t;
            end
            act_d[a] = 1'b1;
          end
        end
        OP_CAL_TOGGLE: begin
          stonly_d  = 1'b0;
          lastidx_d = 2'd2;
          if (run_q) begin
            motors_d = 1'b0;
            run_d    = 1'b0;
            phase_d  = 2'd0;
          end else begin
            act_d  = '{default: 1'b0};
            dir_d  = '{default: 1'b0};
            dist_d = '{default: '0};
            per_d  = '{default: '0};
            sper_d = '{default: '0};
            tgt_d  = '{default: '0};
            tag_d  = '{default: '0};
            ws_d   = '{default: '0};
            motors_d = 1'b1;
            phase_d  = 2'd0;
            run_d    = 1'b1;
          end
        end
        OP_CAL_TICK: begin
          if (run_q) begin
            stonly_d  = 1'b0;
            lastidx_d = 2'd1;
            case (phase_q)
              2'd0: begin
                for (int a = 0; a < 2; a++) begin
                  dir_d[a]  = 1'b0;
                  per_d[a]  = cfg_i.base_rate;
                  act_d[a]  = 1'b1;
                  ld_d[a]   = 1'b1;
                  ldv_d[a]  = cfg_i.homing_travel & PosMask;
                  dist_d[a] = cfg_i.homing_travel;
                  tgt_d[a]  = '0;
                end
                phase_d = 2'd1;
              end
              2'd1: begin
                for (int a = 0; a < 2; a++) begin
                  if (it.endstops[a]) begin
                    ld_d[a]  = 1'b1;
                    ldv_d[a] = '0;
                    tgt_d[a] = '0;
                    act_d[a] = 1'b0;
                    per_d[a] = '0;
                  end
                end
                if (!act_d[0] && !act_d[1]) begin
                  for (int a = 0; a < 2; a++) begin
                    dir_d[a]  = 1'b1;
                    per_d[a]  = cfg_i.base_rate;
                    act_d[a]  = 1'b1;
                    tgt_d[a]  = cfg_i.homing_travel & PosMask;
                    dist_d[a] = cfg_i.homing_travel;
                  end
                  phase_d = 2'd2;
                end
              end
              2'd2: begin
                for (int a = 0; a < 2; a++) begin
                  if (it.endstops[a+2]) begin
                    ws_d[a]  = pos[a];
                    tgt_d[a] = pos[a];
                    act_d[a] = 1'b0;
                    per_d[a] = '0;
                  end
                end
                if (!act_d[0] && !act_d[1]) begin
                  calib_d = 1'b1;
                  for (int a = 0; a < 2; a++) begin
                    half      = (ws_d[a] >> 1) & PosMask;
                    per_d[a]  = cfg_i.base_rate;
                    dir_d[a]  = 1'b0;
                    tgt_d[a]  = half;
                    act_d[a]  = 1'b1;
                    dist_d[a] = (pos[a] - half) & PosMask;
                  end
                  phase_d = 2'd3;
                end
              end
              default: begin
                for (int a = 0; a < 2; a++) begin
                  half = (ws_q[a] >> 1) & PosMask;
                  if (pos[a] <= half) begin
                    per_d[a] = '0;
                    act_d[a] = 1'b0;
                  end
                end
                // return to centre done: stop as with the toggle
                if (!act_d[0] && !act_d[1]) begin
                  motors_d = 1'b0;
                  run_d    = 1'b0;
                  phase_d  = 2'd0;
                end
              end
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  // result beat
  always_comb begin
    res_o        = '0;
    res_o.status = {calib_q, run_q, motors_q};
    res_o.last   = (idx_q == lastidx_q);
    if (stonly_q) begin
      res_o.axis = AXIS_STATUS;
    end else begin
      res_o.axis         = idx_q;
      res_o.active       = act_q[idx_q];
      res_o.direction    = dir_q[idx_q];
      res_o.distance     = dist_q[idx_q];
      res_o.period       = per_q[idx_q];
      res_o.start_period = sper_q[idx_q];
      res_o.target       = tgt_q[idx_q];
      res_o.move_tag     = tag_q[idx_q];
      if (idx_q != 2'd2) begin
        res_o.load_position  = ld_q[idx_q[0]];
        res_o.position_value = ldv_q[idx_q[0]];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      idx_q     <= 2'd0;
      lastidx_q <= 2'd0;
      stonly_q  <= 1'b1;
      act_q  <= '{default: 1'b0};
      dir_q  <= '{default: 1'b0};
      dist_q <= '{default: '0};
      per_q  <= '{default: '0};
      sper_q <= '{default: '0};
      tgt_q  <= '{default: '0};
      tag_q  <= '{default: '0};
      ws_q   <= '{default: '0};
      ld_q   <= '{default: 1'b0};
      ldv_q  <= '{default: '0};
      calib_q  <= 1'b0;
      motors_q <= 1'b0;
      run_q    <= 1'b0;
      phase_q  <= 2'd0;
    end else begin
      st_q      <= st_d;
      idx_q     <= idx_d;
      lastidx_q <= lastidx_d;
      stonly_q  <= stonly_d;
      act_q  <= act_d;
      dir_q  <= dir_d;
      dist_q <= dist_d;
      per_q  <= per_d;
      sper_q <= sper_d;
      tgt_q  <= tgt_d;
      tag_q  <= tag_d;
      ws_q   <= ws_d;
      ld_q   <= ld_d;
      ldv_q  <= ldv_d;
      calib_q  <= calib_d;
      motors_q <= motors_d;
      run_q    <= run_d;
      phase_q  <= phase_d;
    end
  end

  a_phase_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !run_q |-> (phase_q == 2'd0))
    else $error("calibration phase set while not calibrating");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_EMIT) |-> (idx_q <= lastidx_q))
    else $error("result index past last beat");

  a_take_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && st_q == ST_EMIT) |-> (res_wr_o && idx_q == lastidx_q))
    else $error("new command taken before all beats were written");

endmodule

`default_nettype wire

### rtl/axis_move_and_homing_sequencer.sv
// Path: results are registered in the executor, then in the result queue, before the ports.
// Throughput: one result beat per cycle while the result queue is not full; a command
// has 1 to 3 results, written one at a time through the executor's single result write port.
// Reset: asynchronous, active low; axis records, flags and queues clear at once,
// registers return to start 1000, normal 500, homing travel 200000.
// ----------------------------------------------------------------------------
// axis_move_and_homing_sequencer
// Top level: configuration registers, command front queue, executor and
// result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module axis_move_and_homing_sequencer #(
  parameter int unsigned POS_WIDTH = axmh_pkg::POS_WIDTH_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push,
  output logic                            full,
  input  wire axmh_pkg::in_item_t          in_data_i,
  output logic                            empty,
  input  wire logic                       pop,
  output axmh_pkg::out_item_t             out_data_o,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [axmh_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import axmh_pkg::*;

  cfg_t      cfg_q;
  head_t     head;
  logic      q_pop, res_wr, res_full;
  out_item_t res;
  logic      cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slow_start    <= SLOW_START_RST;
      cfg_q.base_rate     <= BASE_RATE_RST;
      cfg_q.homing_travel <= HOMING_TRAVEL_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_SLOW_START:    cfg_q.slow_start    <= pwdata[15:0];
        REG_BASE_RATE:     cfg_q.base_rate     <= pwdata[15:0];
        REG_HOMING_TRAVEL: cfg_q.homing_travel <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SLOW_START:    prdata = {16'd0, cfg_q.slow_start};
      REG_BASE_RATE:     prdata = {16'd0, cfg_q.base_rate};
      REG_HOMING_TRAVEL: prdata = cfg_q.homing_travel;
      default:           prdata = '0;
    endcase
  end

  axmh_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (in_data_i),
    .full_o (full),
    .head_o (head),
    .pop_i  (q_pop)
  );

  axmh_back #(
    .POS_WIDTH (POS_WIDTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .head_i     (head),
    .pop_o      (q_pop),
    .res_wr_o   (res_wr),
    .res_o      (res),
    .res_full_i (res_full)
  );

  axmh_res_q u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (res_wr),
    .data_i  (res),
    .full_o  (res_full),
    .empty_o (empty),
    .data_o  (out_data_o),
    .rd_i    (pop)
  );

endmodule

`default_nettype wire
